[src/wpic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wpic_pkg;

  // operation code of one input transfer
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_ITEM_THR  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  localparam int unsigned DIST_W  = 10;
  localparam int unsigned THR_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned PEAK_W  = 5;
  localparam int unsigned CHAN_N  = 3;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DIST_W-1:0]  BAND_LOW_RST  = 10'd0;
  localparam logic [DIST_W-1:0]  BAND_HIGH_RST = 10'd1023;
  localparam logic [THR_W-1:0]   ITEM_THR_RST  = 5'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [PEAK_W-1:0]  PEAK_OUT_MAX  = 5'd31;

  // request into the history memory
  typedef struct packed {
    logic              en;
    logic              wr;
    logic [CHAN_N-1:0] wdata;
  } hist_req_t;

  // response from the history memory, registered, in the cycle after the request
  typedef struct packed {
    logic [CHAN_N-1:0] old;
  } hist_rsp_t;

endpackage

`default_nettype wire

[src/wpic_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wpic_in_if import wpic_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [DIST_W-1:0] distance_a;
  logic [DIST_W-1:0] distance_b;
  logic [DIST_W-1:0] distance_c;

  modport source (output valid, output op, output distance_a, output distance_b,
                  output distance_c, input ready);
  modport sink (input valid, input op, input distance_a, input distance_b,
                input distance_c, output ready);
endinterface

interface wpic_out_if import wpic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] item_count;
  logic [PEAK_W-1:0]  peak_window_sum;
  logic [CHAN_N-1:0]  present_bits;

  modport source (output valid, output item_count, output peak_window_sum,
                  output present_bits, input ready);
  modport sink (input valid, input item_count, input peak_window_sum,
                input present_bits, output ready);
endinterface

`default_nettype wire

[src/wpic_hist.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpic_hist import wpic_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire hist_req_t req_i,
  output hist_rsp_t      rsp_o
);

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [CHAN_N-1:0] mem [WINDOW];

  logic [PTR_W-1:0]  pos_q, pos_d;
  logic              wrapped_q, wrapped_d;
  logic [CHAN_N-1:0] rd_q;
  logic              rd_vld_q;

  always_comb begin
    pos_d     = pos_q;
    wrapped_d = wrapped_q;
    if (req_i.en && req_i.wr) begin
      if (pos_q == PTR_LAST) begin
        pos_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      wrapped_q <= wrapped_d;
    end
  end

  // read returns the entry as it was before this cycle's write
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      rd_q     <= mem[pos_q];
      rd_vld_q <= wrapped_q;
      if (req_i.wr) begin
        mem[pos_q] <= req_i.wdata;
      end
    end
  end

  // entries not yet written on the first pass read as cleared
  assign rsp_o.old = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[src/windowed_presence_item_counter.sv]
`timescale 1ns / 1ps
`default_nettype none

// windowed presence item counter
// in_i carries one transfer per item: op plus three distance samples.
// a sample op flags each distance inside [band_low, band_high], pushes the
// flags into a WINDOW deep history memory and updates three running sums
// (add new flag, drop the flag WINDOW samples old). the largest sum is the
// peak; a fall of the peak from at or above the count threshold to below
// it bumps the saturating item count. a clear op zeroes only the count.
// out_o returns one result transfer per input transfer, in order.
// three register stages (memory read, sum update, peak and count).
// throughput: one item per cycle, set by the single-port read-modify-write
// of the history memory. a stalled receiver holds the output register and
// freezes the whole pipeline; in_i.ready drops only while a result waits
// and out_o.ready is low. reset clears sums, peak, count and the history
// fill state; registers go to band 0..1023 and threshold 8. the apb port
// writes in the access phase, pready is always high, registers at byte
// 4 * index.
module windowed_presence_item_counter import wpic_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  wpic_in_if.sink                in_i,
  wpic_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned SUM_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // configuration registers
  logic [DIST_W-1:0] band_low_q;
  logic [DIST_W-1:0] band_high_q;
  logic [THR_W-1:0]  item_thr_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      item_thr_q  <= ITEM_THR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BAND_LOW:  band_low_q  <= pwdata[DIST_W-1:0];
        REG_BAND_HIGH: band_high_q <= pwdata[DIST_W-1:0];
        REG_ITEM_THR:  item_thr_q  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BAND_LOW:  prdata = DATA_W'(band_low_q);
      REG_BAND_HIGH: prdata = DATA_W'(band_high_q);
      REG_ITEM_THR:  prdata = DATA_W'(item_thr_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline advance: output register free or being drained
  logic out_vld_q;
  logic adv;
  logic acc;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;

  // stage 0: band flags and history access
  logic [CHAN_N-1:0] flags;
  hist_req_t         hreq;
  hist_rsp_t         hrsp;

  assign flags[0] = (in_i.distance_a >= band_low_q) && (in_i.distance_a <= band_high_q);
  assign flags[1] = (in_i.distance_b >= band_low_q) && (in_i.distance_b <= band_high_q);
  assign flags[2] = (in_i.distance_c >= band_low_q) && (in_i.distance_c <= band_high_q);

  assign hreq.en    = acc;
  assign hreq.wr    = (in_i.op == OP_SAMPLE);
  assign hreq.wdata = flags;

  wpic_hist #(
    .WINDOW (WINDOW)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  // stage 1: running sums, old flags arrive from the memory here
  logic              s1_vld_q;
  op_e               s1_op_q;
  logic [CHAN_N-1:0] s1_bits_q;
  logic [SUM_W-1:0]  sum_q [CHAN_N];
  logic [SUM_W-1:0]  sum_d [CHAN_N];

  always_comb begin
    for (int c = 0; c < CHAN_N; c++) begin
      sum_d[c] = sum_q[c] + SUM_W'(s1_bits_q[c]) - SUM_W'(hrsp.old[c]);
    end
  end

  // stage 2: peak, falling crossing, item count
  logic              s2_vld_q;
  op_e               s2_op_q;
  logic [CHAN_N-1:0] s2_bits_q;
  logic [SUM_W-1:0]  prev_peak_q;
  logic [COUNT_W-1:0] count_q;
  logic [SUM_W-1:0]  peak_ab;
  logic [SUM_W-1:0]  peak;
  logic              fell;
  logic [SUM_W-1:0]  peak_res;
  logic [PEAK_W-1:0] peak_sat;

  assign peak_ab = (sum_q[1] > sum_q[0]) ? sum_q[1] : sum_q[0];
  assign peak    = (sum_q[2] > peak_ab) ? sum_q[2] : peak_ab;
  assign fell    = (CMP_W'(peak) < CMP_W'(item_thr_q)) &&
                   (CMP_W'(prev_peak_q) >= CMP_W'(item_thr_q));

  // clear op reports the kept peak of the last sample
  assign peak_res = (s2_op_q == OP_CLEAR) ? prev_peak_q : peak;
  assign peak_sat = (CMP_W'(peak_res) > CMP_W'(PEAK_OUT_MAX)) ? PEAK_OUT_MAX
                                                              : PEAK_W'(peak_res);

  // output register
  logic [COUNT_W-1:0] res_count_q;
  logic [PEAK_W-1:0]  res_peak_q;
  logic [CHAN_N-1:0]  res_bits_q;
  logic [COUNT_W-1:0] count_d;

  always_comb begin
    count_d = count_q;
    if (s2_op_q == OP_CLEAR) begin
      count_d = '0;
    end else if (fell && (count_q != COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      prev_peak_q <= '0;
      count_q     <= '0;
      for (int c = 0; c < CHAN_N; c++) begin
        sum_q[c] <= '0;
      end
    end else if (adv) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
      if (s1_vld_q && (s1_op_q == OP_SAMPLE)) begin
        for (int c = 0; c < CHAN_N; c++) begin
          sum_q[c] <= sum_d[c];
        end
      end
      if (s2_vld_q) begin
        count_q <= count_d;
        if (s2_op_q == OP_SAMPLE) begin
          prev_peak_q <= peak;
        end
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= in_i.op;
      s1_bits_q   <= flags;
      s2_op_q     <= s1_op_q;
      s2_bits_q   <= s1_bits_q;
      res_count_q <= count_d;
      res_peak_q  <= peak_sat;
      res_bits_q  <= (s2_op_q == OP_CLEAR) ? '0 : s2_bits_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.item_count      = res_count_q;
  assign out_o.peak_window_sum = res_peak_q;
  assign out_o.present_bits    = res_bits_q;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import wpic_pkg::*;

  localparam int unsigned SPAN         = 16;
  localparam int unsigned DIST_MAX     = 1023;
  localparam int unsigned SUM_W        = 9;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 91;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PEAK_W-1:0]  peak;
    logic [CHAN_N-1:0]  flags;
  } tally_t;

  // predicts the windowed sums and item count, and holds the results still owed
  class presence_scoreboard;
    logic [DIST_W-1:0]  band_lo;
    logic [DIST_W-1:0]  band_hi;
    logic [THR_W-1:0]   thr;
    logic [CHAN_N-1:0]  history [SPAN];
    int unsigned        slot;
    logic [SUM_W-1:0]   sums [CHAN_N];
    logic [SUM_W-1:0]   last_peak;
    logic [COUNT_W-1:0] count;
    tally_t             pending [$];
    int unsigned        errors;
    int unsigned        results;

    function new();
      band_lo   = BAND_LOW_RST;
      band_hi   = BAND_HIGH_RST;
      thr       = ITEM_THR_RST;
      slot      = 0;
      last_peak = '0;
      count     = '0;
      errors    = 0;
      results   = 0;
      foreach (history[i]) history[i] = '0;
      foreach (sums[i]) sums[i] = '0;
    endfunction

    function void set_register(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_BAND_LOW: begin
          band_lo = value[DIST_W-1:0];
        end
        REG_BAND_HIGH: begin
          band_hi = value[DIST_W-1:0];
        end
        REG_ITEM_THR: begin
          thr = value[THR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [PEAK_W-1:0] clip(logic [SUM_W-1:0] p);
      return (p > PEAK_OUT_MAX) ? PEAK_OUT_MAX : p[PEAK_W-1:0];
    endfunction

    function void note_input(op_e op, logic [DIST_W-1:0] da, logic [DIST_W-1:0] db,
                             logic [DIST_W-1:0] dc);
      tally_t            t;
      logic [CHAN_N-1:0] flags;
      logic [CHAN_N-1:0] gone;
      logic [SUM_W-1:0]  peak;
      logic [DIST_W-1:0] reading [CHAN_N];
      if (op == OP_CLEAR) begin
        // only the count goes, windows and previous peak stay
        count   = '0;
        t.count = count;
        t.peak  = clip(last_peak);
        t.flags = '0;
        pending.push_back(t);
        return;
      end
      reading = '{da, db, dc};
      gone = history[slot];
      peak = '0;
      for (int ch = 0; ch < CHAN_N; ch++) begin
        flags[ch] = (reading[ch] >= band_lo) && (reading[ch] <= band_hi);
        sums[ch]  = sums[ch] + flags[ch] - gone[ch];
        if (sums[ch] > peak) peak = sums[ch];
      end
      history[slot] = flags;
      slot = (slot + 1) % SPAN;
      if (peak < thr && last_peak >= thr && count != COUNT_MAX) count++;
      last_peak = peak;
      t.count = count;
      t.peak  = clip(peak);
      t.flags = flags;
      pending.push_back(t);
    endfunction

    task report(string msg);
      errors++;
      $display("%s", msg);
    endtask

    task check_result(logic [COUNT_W-1:0] cnt, logic [PEAK_W-1:0] peak,
                      logic [CHAN_N-1:0] flags);
      tally_t want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d: arrived with nothing expected", results));
        return;
      end
      want = pending.pop_front();
      if (cnt !== want.count)
        report($sformatf("result %0d: item_count %0d, want %0d", results, cnt, want.count));
      if (peak !== want.peak)
        report($sformatf("result %0d: peak_window_sum %0d, want %0d", results, peak,
                         want.peak));
      if (flags !== want.flags)
        report($sformatf("result %0d: present_bits %b, want %b", results, flags,
                         want.flags));
    endtask

    function int unsigned waiting();
      return pending.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wpic_in_if  in_bus ();
  wpic_out_if out_bus ();

  presence_scoreboard board = new();

  // current band, used to aim distances inside or just outside it
  logic [DIST_W-1:0] cur_lo;
  logic [DIST_W-1:0] cur_hi;
  // idle odds in percent per cycle for each side
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       cycles;

  windowed_presence_item_counter #(
    .WINDOW (SPAN)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on the whole run
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // both sides observed at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        board.note_input(in_bus.op, in_bus.distance_a, in_bus.distance_b, in_bus.distance_c);
      if (out_bus.valid && out_bus.ready)
        board.check_result(out_bus.item_count, out_bus.peak_window_sum, out_bus.present_bits);
    end
  end

  // receiver side, stalls at the odds of the current phase
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void set_pace(int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 58; recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;  recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct = 26; recv_stall_pct = 26;
      end
    endcase
  endfunction

  // a distance inside the band (often right on its edges) or outside it (often just outside)
  function automatic logic [DIST_W-1:0] pick_distance(bit want_in);
    bit go_low;
    if (cur_lo > cur_hi || (!want_in && cur_lo == 0 && cur_hi == DIST_MAX))
      return DIST_W'($urandom_range(DIST_MAX));
    if (want_in) begin
      case ($urandom_range(3))
        0: return cur_lo;
        1: return cur_hi;
        default: return DIST_W'($urandom_range(cur_hi, cur_lo));
      endcase
    end
    go_low = (cur_lo != 0) && (cur_hi == DIST_MAX || $urandom_range(1) == 1);
    if (go_low)
      return DIST_W'($urandom_range(1) ? cur_lo - 1 : $urandom_range(cur_lo - 1, 0));
    return DIST_W'($urandom_range(1) ? cur_hi + 1 : $urandom_range(DIST_MAX, cur_hi + 1));
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(op_e op, logic [DIST_W-1:0] da, logic [DIST_W-1:0] db,
                           logic [DIST_W-1:0] dc);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.distance_a <= da;
    in_bus.distance_b <= db;
    in_bus.distance_c <= dc;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // sender goes quiet until every owed result is out, then pipeline flush
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle, written when pready is high
  task automatic write_register(reg_idx_e idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk, the block keeps only the field width
  task automatic configure(logic [DIST_W-1:0] lo, logic [DIST_W-1:0] hi,
                           logic [THR_W-1:0] thr);
    logic [DATA_W-1:0] data;
    settle();
    data = $urandom();
    data[DIST_W-1:0] = lo;
    write_register(REG_BAND_LOW, data);
    data = $urandom();
    data[DIST_W-1:0] = hi;
    write_register(REG_BAND_HIGH, data);
    data = $urandom();
    data[THR_W-1:0] = thr;
    write_register(REG_ITEM_THR, data);
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // random bursts, each channel with its own presence density, so the
  // window sums climb and drain across the threshold; some noise and clears
  task automatic run_phase(int unsigned count_items);
    int unsigned       burst_left;
    int unsigned       density [CHAN_N];
    logic [DIST_W-1:0] reading [CHAN_N];
    burst_left = 0;
    for (int unsigned i = 0; i < count_items; i++) begin
      if (i == count_items / 2) settle();
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 4);
        for (int ch = 0; ch < CHAN_N; ch++) density[ch] = $urandom_range(100);
      end
      burst_left--;
      for (int ch = 0; ch < CHAN_N; ch++)
        reading[ch] = ($urandom_range(9) == 0) ? DIST_W'($urandom())
                                                : pick_distance($urandom_range(99) < density[ch]);
      send_item(($urandom_range(15) == 0) ? OP_CLEAR : OP_SAMPLE,
                reading[0], reading[1], reading[2]);
    end
  endtask

  // stimulus and end of run
  initial begin
    int unsigned       phase_lo [PHASES];
    int unsigned       phase_hi [PHASES];
    int unsigned       phase_thr [PHASES];
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_SAMPLE;
    in_bus.distance_a = '0;
    in_bus.distance_b = '0;
    in_bus.distance_c = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    cur_lo  = BAND_LOW_RST;
    cur_hi  = BAND_HIGH_RST;
    set_pace(0);

    // band extremes, a one-point band, an empty band, threshold zero,
    // threshold at the window size and above it, then a random setting
    phase_lo  = '{0,    300, 512, 800, 100, 1023, 200,  0};
    phase_hi  = '{1023, 700, 512, 200, 900, 1023, 1023, 0};
    phase_thr = '{8,    1,   4,   3,   16,  0,    31,   0};
    phase_lo[PHASES-1]  = $urandom_range(DIST_MAX);
    phase_hi[PHASES-1]  = $urandom_range(DIST_MAX, phase_lo[PHASES-1]);
    phase_thr[PHASES-1] = $urandom_range(SPAN, 1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: clear on a fresh block, then field extremes
    send_item(OP_CLEAR, 10'd1023, 10'd1023, 10'd1023);
    send_item(OP_SAMPLE, 10'd0, 10'd0, 10'd0);
    send_item(OP_SAMPLE, 10'd1023, 10'd1023, 10'd1023);
    send_item(OP_SAMPLE, 10'd0, 10'd1023, 10'd512);

    // wide band: a short present run mostly on the edges, then a long absent
    // run outside them drains the peak below the threshold once
    configure(10'd5, 10'd1000, 5'd2);
    send_item(OP_SAMPLE, 10'd5, 10'd1000, 10'd500);
    send_item(OP_SAMPLE, 10'd1000, 10'd5, 10'd5);
    send_item(OP_SAMPLE, 10'd500, 10'd500, 10'd1000);
    for (int n = 0; n < SPAN; n++)
      send_item(OP_SAMPLE, 10'd4, 10'd1001, n[0] ? 10'd0 : 10'd1023);
    send_item(OP_CLEAR, 10'd682, 10'd341, 10'd0);

    // random phases, cycling through the idle patterns
    for (int unsigned p = 0; p < PHASES; p++) begin
      configure(DIST_W'(phase_lo[p]), DIST_W'(phase_hi[p]), THR_W'(phase_thr[p]));
      set_pace(p % 4);
      run_phase(PHASE_ITEMS);
    end

    settle();
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
